FILE: rtl/core/i2crm_pkg.sv
`default_nettype none

package i2crm_pkg;

  // command kinds carried by an input transaction
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // completion status codes
  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_OK    = 2'd1;
  localparam logic [1:0] STATUS_ABORT = 2'd2;

  // configuration register indexes
  localparam logic CFG_DEVICE_ADDR = 1'b0;
  localparam logic CFG_PHASE_TICKS = 1'b1;

  localparam int CFG_DATA_W = 16;

  localparam logic [6:0]  DEVICE_ADDR_RESET = 7'd104;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd8;

  // front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic [1:0] status;
  } res_t;

  // classified tick as held in the queue
  typedef struct packed {
    logic       is_cmd;
    logic       is_read;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda;
  } tick_t;

endpackage

`default_nettype wire

FILE: rtl/core/i2crm_front.sv
`default_nettype none

module i2crm_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  output logic                cmd_stall,
  input  i2crm_pkg::cmd_t     cmd,
  output logic                head_valid,
  output i2crm_pkg::tick_t    head,
  input  wire                 pop
);

  i2crm_pkg::tick_t                 entries [i2crm_pkg::QUEUE_DEPTH];
  logic [i2crm_pkg::QPTR_W-1:0]     wr_ptr;
  logic [i2crm_pkg::QPTR_W-1:0]     rd_ptr;
  logic [i2crm_pkg::QCNT_W-1:0]     count;
  logic                             push;
  i2crm_pkg::tick_t                 classified;

  localparam logic [i2crm_pkg::QPTR_W-1:0] LAST_PTR =
    i2crm_pkg::QPTR_W'(i2crm_pkg::QUEUE_DEPTH - 1);
  localparam logic [i2crm_pkg::QCNT_W-1:0] FULL_CNT =
    i2crm_pkg::QCNT_W'(i2crm_pkg::QUEUE_DEPTH);

  // kind three is treated like a plain tick
  always_comb begin
    classified.is_cmd     = (cmd.kind == i2crm_pkg::KIND_WRITE) ||
                            (cmd.kind == i2crm_pkg::KIND_READ);
    classified.is_read    = (cmd.kind == i2crm_pkg::KIND_READ);
    classified.reg_addr   = cmd.reg_addr;
    classified.write_data = cmd.write_data;
    classified.read_count = cmd.read_count;
    classified.sda        = cmd.sda_in;
  end

  assign cmd_stall  = (count == FULL_CNT);
  assign push       = cmd_valid && !cmd_stall;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("queue count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count != '0)) else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/i2crm_back.sv
`default_nettype none

module i2crm_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 head_valid,
  input  i2crm_pkg::tick_t    head,
  output logic                pop,
  input  wire  [6:0]          device_addr,
  input  wire  [15:0]         phase_ticks,
  output logic                res_valid,
  input  wire                 res_stall,
  output i2crm_pkg::res_t     res
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_PRESTOP = 4'd1;
  localparam logic [3:0] ST_START1  = 4'd2;
  localparam logic [3:0] ST_CTRLW   = 4'd3;
  localparam logic [3:0] ST_REG     = 4'd4;
  localparam logic [3:0] ST_DATA    = 4'd5;
  localparam logic [3:0] ST_MIDSTOP = 4'd6;
  localparam logic [3:0] ST_START2  = 4'd7;
  localparam logic [3:0] ST_CTRLR   = 4'd8;
  localparam logic [3:0] ST_READ    = 4'd9;
  localparam logic [3:0] ST_FINSTOP = 4'd10;

  logic [3:0]  seq_step,    seq_step_next;
  logic [1:0]  sub_phase,   sub_phase_next;
  logic [15:0] phase_count, phase_count_next;
  logic [3:0]  bit_index,   bit_index_next;
  logic [7:0]  shift_byte,  shift_byte_next;
  logic [7:0]  bytes_left,  bytes_left_next;
  logic [7:0]  held_reg,    held_reg_next;
  logic [7:0]  held_data,   held_data_next;
  logic        is_read,     is_read_next;
  logic        ack_bit,     ack_bit_next;
  logic        failed,      failed_next;
  i2crm_pkg::res_t res_next;

  assign pop = head_valid && (!res_valid || !res_stall);

  always_comb begin
    logic [3:0]  step;
    logic [1:0]  sub;
    logic [15:0] pc;
    logic [3:0]  bi;
    logic [7:0]  sb;
    logic [7:0]  bl;
    logic [7:0]  hr;
    logic [7:0]  hd;
    logic        ir;
    logic        ack;
    logic        fl;
    logic [16:0] len;
    logic [16:0] pc_inc;
    logic        bitstep;
    logic        fin;

    step = seq_step;
    sub  = sub_phase;
    pc   = phase_count;
    bi   = bit_index;
    sb   = shift_byte;
    bl   = bytes_left;
    hr   = held_reg;
    hd   = held_data;
    ir   = is_read;
    ack  = ack_bit;
    fl   = failed;
    res_next = '0;
    res_next.scl_level = 1'b1;
    res_next.sda_level = 1'b1;

    // command is taken only while idle; its tick is the first of the opening stop
    if (step == ST_IDLE && head.is_cmd) begin
      hr   = head.reg_addr;
      hd   = head.write_data;
      bl   = head.read_count;
      ir   = head.is_read;
      fl   = 1'b0;
      ack  = 1'b0;
      step = ST_PRESTOP;
      sub  = 2'd0;
      pc   = '0;
      bi   = '0;
      sb   = '0;
    end

    bitstep = step inside {ST_CTRLW, ST_REG, ST_DATA, ST_CTRLR, ST_READ};
    len     = (phase_ticks == '0) ? 17'd1 : {1'b0, phase_ticks};
    pc_inc  = {1'b0, pc} + 17'd1;
    fin     = (pc_inc >= len);

    if (step != ST_IDLE) begin
      res_next.busy_res = 1'b1;
      if (bitstep) begin
        res_next.scl_level = (sub == 2'd1);
        if (bi >= 4'd8) begin
          res_next.sda_level = (step == ST_READ) ? (bl == 8'd1) : 1'b1;
        end else begin
          res_next.sda_level = (step == ST_READ) ? 1'b1 : sb[7];
        end
      end else if (step == ST_START1 || step == ST_START2) begin
        res_next.scl_level = (sub < 2'd2);
        res_next.sda_level = (sub == 2'd0);
      end else begin
        res_next.scl_level = (sub >= 2'd1);
        res_next.sda_level = (sub == 2'd2);
      end

      pc = fin ? '0 : pc_inc[15:0];

      if (fin) begin
        if (sub == 2'd0) begin
          sub = 2'd1;
        end else if (sub == 2'd1) begin
          sub = 2'd2;
          // SDA sampled at the end of the SCL-high phase
          if (bitstep) begin
            if (bi >= 4'd8) begin
              ack = head.sda;
            end else if (step == ST_READ) begin
              sb = {sb[6:0], head.sda};
              if (bi == 4'd7) begin
                res_next.byte_valid = 1'b1;
                res_next.read_byte  = sb;
                res_next.last_byte  = (bl == 8'd1);
              end
            end
          end
        end else begin
          sub = 2'd0;
          if (bitstep && bi < 4'd8) begin
            bi = bi + 4'd1;
            if (step != ST_READ) begin
              sb = {sb[6:0], 1'b0};
            end
          end else if (bitstep && step != ST_READ) begin
            if (ack) begin
              fl   = 1'b1;
              step = ST_FINSTOP;
            end else begin
              case (step)
                ST_CTRLW: begin
                  step = ST_REG;
                  sb   = hr;
                  bi   = '0;
                end
                ST_REG: begin
                  if (ir) begin
                    step = ST_MIDSTOP;
                  end else begin
                    step = ST_DATA;
                    sb   = hd;
                    bi   = '0;
                  end
                end
                ST_DATA: begin
                  step = ST_FINSTOP;
                end
                default: begin
                  if (bl == 8'd0) begin
                    step = ST_FINSTOP;
                  end else begin
                    step = ST_READ;
                    bi   = '0;
                    sb   = '0;
                  end
                end
              endcase
            end
          end else if (bitstep) begin
            bl = bl - 8'd1;
            bi = '0;
            sb = '0;
            if (bl == 8'd0) begin
              step = ST_FINSTOP;
            end
          end else begin
            case (step)
              ST_PRESTOP: begin
                step = ST_START1;
              end
              ST_START1: begin
                step = ST_CTRLW;
                sb   = {device_addr, 1'b0};
                bi   = '0;
              end
              ST_MIDSTOP: begin
                step = ST_START2;
              end
              ST_START2: begin
                step = ST_CTRLR;
                sb   = {device_addr, 1'b1};
                bi   = '0;
              end
              default: begin
                res_next.status = fl ? i2crm_pkg::STATUS_ABORT : i2crm_pkg::STATUS_OK;
                step = ST_IDLE;
                bi   = '0;
              end
            endcase
          end
        end
      end
    end

    seq_step_next    = step;
    sub_phase_next   = sub;
    phase_count_next = pc;
    bit_index_next   = bi;
    shift_byte_next  = sb;
    bytes_left_next  = bl;
    held_reg_next    = hr;
    held_data_next   = hd;
    is_read_next     = ir;
    ack_bit_next     = ack;
    failed_next      = fl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_step    <= ST_IDLE;
      sub_phase   <= '0;
      phase_count <= '0;
      bit_index   <= '0;
      shift_byte  <= '0;
      bytes_left  <= '0;
      held_reg    <= '0;
      held_data   <= '0;
      is_read     <= 1'b0;
      ack_bit     <= 1'b0;
      failed      <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (pop) begin
        seq_step    <= seq_step_next;
        sub_phase   <= sub_phase_next;
        phase_count <= phase_count_next;
        bit_index   <= bit_index_next;
        shift_byte  <= shift_byte_next;
        bytes_left  <= bytes_left_next;
        held_reg    <= held_reg_next;
        held_data   <= held_data_next;
        is_read     <= is_read_next;
        ack_bit     <= ack_bit_next;
        failed      <= failed_next;
        res_valid   <= 1'b1;
      end else if (!res_stall) begin
        res_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

`ifndef SYNTH
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (seq_step == ST_IDLE) |-> (bit_index == '0 && sub_phase == '0))
    else $error("idle sequencer with stale bit or phase");
  a_status_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != i2crm_pkg::STATUS_NONE) |-> res.busy_res)
    else $error("status reported outside a transaction");
  a_byte_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.byte_valid) |-> (res.busy_res && res.scl_level))
    else $error("byte delivered outside an SCL-high read phase");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/i2c_register_master_core.sv
`default_nettype none
// An accepted tick is registered first into the tick queue and then into the result
// register; a stalled result channel can hold it in the queue between the two.
// Throughput: one tick per clock while the result channel is not stalled.
// The four-entry queue lets the input side keep taking ticks while results wait.
// Reset (rst, synchronous, high) empties the queue, idles the sequencer, drops
// res_valid, and loads address 104 and an 8-tick phase.

module i2c_register_master_core (
  input  wire                                  clk,
  input  wire                                  rst,
  // tick/command channel
  input  wire                                  cmd_valid,
  output logic                                 cmd_stall,
  input  i2crm_pkg::cmd_t                      cmd,
  // result channel
  output logic                                 res_valid,
  input  wire                                  res_stall,
  output i2crm_pkg::res_t                      res,
  // configuration writes
  input  wire                                  cfg_we,
  input  wire                                  cfg_index,
  input  wire  [i2crm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [6:0]        device_addr;
  logic [15:0]       phase_ticks;
  logic              head_valid;
  i2crm_pkg::tick_t  head;
  logic              pop;

  // Config registers; a write takes effect on the next queued tick. A bus
  // access may still be running, so a phase length cut below the ticks
  // already spent ends the current phase at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_addr <= i2crm_pkg::DEVICE_ADDR_RESET;
      phase_ticks <= i2crm_pkg::PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2crm_pkg::CFG_DEVICE_ADDR: device_addr <= cfg_data[6:0];
        i2crm_pkg::CFG_PHASE_TICKS: phase_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Front: decode the tick kind and buffer it.
  i2crm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Back: bus sequencer, one queued tick per step, result register on the way out.
  i2crm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .device_addr (device_addr),
    .phase_ticks (phase_ticks),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res)
  );

endmodule

`default_nettype wire
